// ===== src/assert_macros.svh =====
// Assertion macros shared by the button press classifier RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// Next-cycle implication, checked out of reset.
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

// ===== src/bpc_pkg.sv =====
// Package for the button press classifier: types, event codes, register indexes.
// No dependencies; imported by every module of the block.
package bpc_pkg;

    localparam int NUM_KEYS = 3;
    localparam int KEY_W    = 2;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    localparam logic [KEY_W-1:0] SHORT_NONE = 2'd3;

    // event codes
    localparam logic [2:0] KIND_PRESS        = 3'd0;
    localparam logic [2:0] KIND_RELEASE      = 3'd1;
    localparam logic [2:0] KIND_SHORT        = 3'd2;
    localparam logic [2:0] KIND_DOUBLE       = 3'd3;
    localparam logic [2:0] KIND_LONG_RELEASE = 3'd4;
    localparam logic [2:0] KIND_HOLD         = 3'd5;
    localparam logic [2:0] KIND_LONG         = 3'd6;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_HOLD     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG     = 3'd2;
    localparam logic [IDX_W-1:0] REG_REPEAT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOUBLE   = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] long_ms;
        logic [CFG_W-1:0] repeat_ms;
        logic [CFG_W-1:0] double_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] pressed_levels;
        logic [TIME_W-1:0]   now_ms;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic [2:0]        event_kind;
        logic              repeat_flag;
        logic [TIME_W-1:0] length_ms;
        logic [TIME_W-1:0] occurred_ms;
    } out_t;

    // what one key lane proposes for the current sample
    typedef struct packed {
        logic              valid;
        logic [2:0]        kind;
        logic              repeat_flag;
        logic [TIME_W-1:0] duration;
        logic              short_set;
        logic              short_clear;
    } lane_evt_t;

endpackage

// ===== src/bpc_lane.sv =====
// One key lane: debounce state, press timing and event classification for a key.
// Depends on bpc_pkg; state is updated only when the merge stage commits it.
module bpc_lane
    import bpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              level,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    input  logic              short_match,
    input  logic [TIME_W-1:0] short_time,
    input  logic              commit,
    output lane_evt_t         evt
);

    logic              raw_level_reg, raw_level_next;
    logic              stable_level_reg, stable_level_next;
    logic              long_rep_reg, long_rep_next;
    logic              hold_rep_reg, hold_rep_next;
    logic              edge_pend_reg, edge_pend_next;
    logic              edge_rel_reg, edge_rel_next;
    logic [TIME_W-1:0] raw_time_reg, raw_time_next;
    logic [TIME_W-1:0] stable_time_reg, stable_time_next;
    logic [TIME_W-1:0] long_time_reg, long_time_next;

    logic              raw_chg, deb_ok, deb, held_cond, lr_eff, hr_eff;
    logic [TIME_W-1:0] since_raw, since_stable, since_long, since_short;
    logic [TIME_W-1:0] held, since_long_eff;

    // elapsed times, all wrapping
    assign since_raw    = now_ms - raw_time_reg;
    assign since_stable = now_ms - stable_time_reg;
    assign since_long   = now_ms - long_time_reg;
    assign since_short  = now_ms - short_time;

    // debounce: a fresh raw change has zero elapsed time
    assign raw_chg = level != raw_level_reg;
    assign deb_ok  = raw_chg ? (cfg.debounce_ms == '0)
                             : (since_raw >= {16'd0, cfg.debounce_ms});
    assign deb     = (level != stable_level_reg) && deb_ok;

    // values seen by the hold / long checks after a debounced press
    assign held           = deb ? '0 : since_stable;
    assign since_long_eff = deb ? '0 : since_long;
    assign lr_eff         = deb ? 1'b0 : long_rep_reg;
    assign hr_eff         = deb ? 1'b0 : hold_rep_reg;
    assign held_cond      = level && (deb ? level : stable_level_reg);

    // classification
    always_comb begin
        raw_level_next    = raw_level_reg;
        stable_level_next = stable_level_reg;
        long_rep_next     = long_rep_reg;
        hold_rep_next     = hold_rep_reg;
        edge_pend_next    = edge_pend_reg;
        edge_rel_next     = edge_rel_reg;
        raw_time_next     = raw_time_reg;
        stable_time_next  = stable_time_reg;
        long_time_next    = long_time_reg;
        evt               = '0;

        if (edge_pend_reg) begin
            // deferred edge ends the visit before anything is latched
            evt.valid      = 1'b1;
            evt.kind       = edge_rel_reg ? KIND_RELEASE : KIND_PRESS;
            edge_pend_next = 1'b0;
            edge_rel_next  = 1'b0;
        end else begin
            raw_level_next = level;
            if (raw_chg) begin
                raw_time_next = now_ms;
            end
            if (deb) begin
                stable_level_next = level;
                stable_time_next  = now_ms;
                edge_pend_next    = 1'b1;
                edge_rel_next     = !level;
                if (level) begin
                    long_rep_next  = 1'b0;
                    hold_rep_next  = 1'b0;
                    long_time_next = now_ms;
                end else begin
                    evt.valid    = 1'b1;
                    evt.duration = since_stable;
                    priority if (long_rep_reg) begin
                        evt.kind = KIND_LONG_RELEASE;
                    end else if (short_match &&
                                 since_short <= {16'd0, cfg.double_window_ms}) begin
                        evt.kind        = KIND_DOUBLE;
                        evt.short_clear = 1'b1;
                    end else begin
                        evt.kind      = KIND_SHORT;
                        evt.short_set = 1'b1;
                    end
                end
            end
            // hold and long-press checks (a debounced release never gets here)
            if (!(deb && !level)) begin
                priority if (held_cond && !hr_eff && held >= {16'd0, cfg.hold_ms}) begin
                    evt.valid     = 1'b1;
                    evt.kind      = KIND_HOLD;
                    evt.duration  = held;
                    hold_rep_next = 1'b1;
                end else if (held_cond && held >= {16'd0, cfg.long_ms} &&
                             (!lr_eff || since_long_eff >= {16'd0, cfg.repeat_ms})) begin
                    evt.valid       = 1'b1;
                    evt.kind        = KIND_LONG;
                    evt.repeat_flag = lr_eff;
                    evt.duration    = held;
                    long_rep_next   = 1'b1;
                    long_time_next  = now_ms;
                end else begin
                    evt.valid = evt.valid;
                end
            end
        end
    end

    // key state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_level_reg    <= 1'b0;
            stable_level_reg <= 1'b0;
            long_rep_reg     <= 1'b0;
            hold_rep_reg     <= 1'b0;
            edge_pend_reg    <= 1'b0;
            edge_rel_reg     <= 1'b0;
            raw_time_reg     <= '0;
            stable_time_reg  <= '0;
            long_time_reg    <= '0;
        end else if (commit) begin
            raw_level_reg    <= raw_level_next;
            stable_level_reg <= stable_level_next;
            long_rep_reg     <= long_rep_next;
            hold_rep_reg     <= hold_rep_next;
            edge_pend_reg    <= edge_pend_next;
            edge_rel_reg     <= edge_rel_next;
            raw_time_reg     <= raw_time_next;
            stable_time_reg  <= stable_time_next;
            long_time_reg    <= long_time_next;
        end
    end

endmodule

// ===== src/bpc_merge.sv =====
// Merge stage: picks the first lane with an event and decides which lanes commit.
// Depends on bpc_pkg; combinational.
module bpc_merge
    import bpc_pkg::*;
(
    input  lane_evt_t           lane_evt [NUM_KEYS],
    input  logic                accept,
    input  logic [TIME_W-1:0]   now_ms,
    output logic [NUM_KEYS-1:0] commit,
    output logic                res_valid,
    output out_t                res,
    output logic                short_set,
    output logic                short_clear
);

    logic found;

    // priority scan: lanes up to and including the first event commit
    always_comb begin
        found       = 1'b0;
        commit      = '0;
        res_valid   = 1'b0;
        res         = '0;
        short_set   = 1'b0;
        short_clear = 1'b0;
        res.occurred_ms = now_ms;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!found) begin
                commit[k] = accept;
                if (lane_evt[k].valid) begin
                    found           = 1'b1;
                    res_valid       = 1'b1;
                    res.key_index   = KEY_W'(k);
                    res.event_kind  = lane_evt[k].kind;
                    res.repeat_flag = lane_evt[k].repeat_flag;
                    res.length_ms   = lane_evt[k].duration;
                    short_set       = lane_evt[k].short_set;
                    short_clear     = lane_evt[k].short_clear;
                end
            end
        end
    end

endmodule

// ===== src/bpc_out_buf.sv =====
// Result buffer: output register plus one skid entry on the result channel.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bpc_out_buf
    import bpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  out_t push_data,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    out_t out_data_reg, out_data_next;
    out_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop     = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // next-state of the two entries
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `BPC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `BPC_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn, push && out_valid_reg && !pop, skid_valid_reg)
    `BPC_ASSERT_NXT(a_skid_drains, aclk, aresetn, skid_valid_reg && pop, out_valid_reg && !skid_valid_reg)

endmodule

// ===== src/button_press_classifier.sv =====
// Button press classifier, top level: config registers, key lanes, merge, result buffer.
// Depends on bpc_pkg, bpc_lane, bpc_merge and bpc_out_buf.
//
// Usage:
//   s_valid/s_ready/s_data carry one sample: pressed levels of the keys and a
//   millisecond timestamp. m_valid/m_ready/m_data carry zero or one event per
//   sample (key, kind, repeat flag, duration, timestamp). cfg_valid/cfg_ready
//   with cfg_index/cfg_data write the five 16-bit timing registers; cfg_ready
//   is always high and unknown indexes are dropped.
//   Throughput: one sample per cycle while s_ready is high. All key lanes evaluate a sample in the
//   same cycle and the merge stage picks the first key with an event, so the
//   state update is registered at the sample's transfer.
//   Output: an event is registered in the output register, or in the skid entry when that stalls.
//   Stall: a one-entry skid behind the output register keeps s_ready high for
//   one more event while m_ready is low; s_ready drops once both are full.
//   Samples with no event never need buffer space but wait on s_ready too.
//   Reset (aresetn low, synchronous): key state cleared, registers back to
//   their defaults (40, 200, 650, 260, 300 ms), both buffer entries empty.
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t                cfg_reg;
    logic [KEY_W-1:0]    short_key_reg;
    logic [TIME_W-1:0]   short_time_reg;
    lane_evt_t           lane_evt [NUM_KEYS];
    logic [NUM_KEYS-1:0] commit;
    logic                in_accept, res_valid, short_set, short_clear;
    out_t                res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms      <= 16'd40;
            cfg_reg.hold_ms          <= 16'd200;
            cfg_reg.long_ms          <= 16'd650;
            cfg_reg.repeat_ms        <= 16'd260;
            cfg_reg.double_window_ms <= 16'd300;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ms      <= cfg_data;
                REG_HOLD:     cfg_reg.hold_ms          <= cfg_data;
                REG_LONG:     cfg_reg.long_ms          <= cfg_data;
                REG_REPEAT:   cfg_reg.repeat_ms        <= cfg_data;
                REG_DOUBLE:   cfg_reg.double_window_ms <= cfg_data;
                default:      cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // one lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        bpc_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .level       (s_data.pressed_levels[k]),
            .now_ms      (s_data.now_ms),
            .cfg         (cfg_reg),
            .short_match (short_key_reg == KEY_W'(k)),
            .short_time  (short_time_reg),
            .commit      (commit[k]),
            .evt         (lane_evt[k])
        );
    end

    bpc_merge u_merge (
        .lane_evt    (lane_evt),
        .accept      (in_accept),
        .now_ms      (s_data.now_ms),
        .commit      (commit),
        .res_valid   (res_valid),
        .res         (res),
        .short_set   (short_set),
        .short_clear (short_clear)
    );

    // last short press, shared across keys for double detection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_key_reg  <= SHORT_NONE;
            short_time_reg <= '0;
        end else if (in_accept && res_valid) begin
            if (short_set) begin
                short_key_reg  <= res.key_index;
                short_time_reg <= s_data.now_ms;
            end else if (short_clear) begin
                short_key_reg  <= SHORT_NONE;
                short_time_reg <= '0;
            end
        end
    end

    bpc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept && res_valid),
        .push_data (res),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== dv/button_press_classifier_tb.sv =====
// Testbench for button_press_classifier: raw key samples in, classified key events out.
// Depends on bpc_pkg and the RTL under src; self-checking against an in-bench event predictor.
`timescale 1ns / 100ps

module button_press_classifier_tb
    import bpc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int DRAIN_CYCLES   = 4;

    // Predicts the key event, if any, for each accepted sample and matches it
    // against the events that come out of the block.
    class press_event_scoreboard;
        cfg_t              timing;
        bit                raw_lvl      [NUM_KEYS];
        bit                stable_lvl   [NUM_KEYS];
        bit                long_seen    [NUM_KEYS];
        bit                hold_seen    [NUM_KEYS];
        bit                edge_due     [NUM_KEYS];
        bit                edge_release [NUM_KEYS];
        logic [TIME_W-1:0] raw_since    [NUM_KEYS];
        logic [TIME_W-1:0] stable_since [NUM_KEYS];
        logic [TIME_W-1:0] long_last    [NUM_KEYS];
        logic [KEY_W-1:0]  short_key;
        logic [TIME_W-1:0] short_time;
        out_t              expected_events[$];
        int                mismatches;

        function new();
            // power-up timing: debounce, hold, long, repeat, double window
            timing = {16'd40, 16'd200, 16'd650, 16'd260, 16'd300};
            for (int k = 0; k < NUM_KEYS; k++) begin
                raw_since[k]    = '0;
                stable_since[k] = '0;
                long_last[k]    = '0;
            end
            short_key  = SHORT_NONE;
            short_time = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: timing.debounce_ms      = val;
                REG_HOLD:     timing.hold_ms          = val;
                REG_LONG:     timing.long_ms          = val;
                REG_REPEAT:   timing.repeat_ms        = val;
                REG_DOUBLE:   timing.double_window_ms = val;
                default: ;
            endcase
        endfunction

        // Keys are visited in order; the first key with an event ends the sample.
        function bit classify_sample(logic [NUM_KEYS-1:0] levels, logic [TIME_W-1:0] now,
                                     output out_t ev);
            logic [TIME_W-1:0] since_raw;
            logic [TIME_W-1:0] since_long;
            logic [TIME_W-1:0] held;
            logic [TIME_W-1:0] press_len;
            logic [TIME_W-1:0] short_gap;
            ev = '0;
            ev.occurred_ms = now;
            for (int k = 0; k < NUM_KEYS; k++) begin
                ev.key_index = KEY_W'(k);

                // deferred press/release edge goes out first
                if (edge_due[k]) begin
                    ev.event_kind = edge_release[k] ? KIND_RELEASE : KIND_PRESS;
                    edge_due[k]     = 1'b0;
                    edge_release[k] = 1'b0;
                    return 1'b1;
                end

                // latch raw change
                if (levels[k] != raw_lvl[k]) begin
                    raw_lvl[k]   = levels[k];
                    raw_since[k] = now;
                end

                // debounce
                since_raw = now - raw_since[k];
                if (raw_lvl[k] != stable_lvl[k] && since_raw >= timing.debounce_ms) begin
                    press_len       = now - stable_since[k];
                    stable_lvl[k]   = raw_lvl[k];
                    stable_since[k] = now;
                    edge_due[k]     = 1'b1;
                    edge_release[k] = !stable_lvl[k];
                    if (stable_lvl[k]) begin
                        long_seen[k] = 1'b0;
                        hold_seen[k] = 1'b0;
                        long_last[k] = now;
                    end else begin
                        ev.length_ms = press_len;
                        short_gap    = now - short_time;
                        if (long_seen[k]) begin
                            ev.event_kind = KIND_LONG_RELEASE;
                        end else if (short_key == KEY_W'(k) &&
                                     short_gap <= timing.double_window_ms) begin
                            ev.event_kind = KIND_DOUBLE;
                            short_key     = SHORT_NONE;
                            short_time    = '0;
                        end else begin
                            ev.event_kind = KIND_SHORT;
                            short_key     = KEY_W'(k);
                            short_time    = now;
                        end
                        return 1'b1;
                    end
                end

                // one-shot hold
                held = now - stable_since[k];
                if (raw_lvl[k] && stable_lvl[k] && !hold_seen[k] && held >= timing.hold_ms) begin
                    hold_seen[k]  = 1'b1;
                    ev.event_kind = KIND_HOLD;
                    ev.length_ms  = held;
                    return 1'b1;
                end

                // long press and auto-repeat
                since_long = now - long_last[k];
                if (raw_lvl[k] && stable_lvl[k] && held >= timing.long_ms &&
                    (!long_seen[k] || since_long >= timing.repeat_ms)) begin
                    ev.repeat_flag = long_seen[k];
                    long_seen[k]   = 1'b1;
                    long_last[k]   = now;
                    ev.event_kind  = KIND_LONG;
                    ev.length_ms   = held;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_sample(in_t smp);
            out_t ev;
            if (classify_sample(smp.pressed_levels, smp.now_ms, ev))
                expected_events.push_back(ev);
        endfunction

        function void check_event(out_t got);
            out_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected event: key %0d kind %0d at %0d",
                       got.key_index, got.event_kind, got.occurred_ms);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            if (got.key_index !== want.key_index) begin
                $error("key_index: expected %0d, got %0d", want.key_index, got.key_index);
                mismatches++;
            end
            if (got.event_kind !== want.event_kind) begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                mismatches++;
            end
            if (got.repeat_flag !== want.repeat_flag) begin
                $error("repeat_flag: expected %0d, got %0d", want.repeat_flag, got.repeat_flag);
                mismatches++;
            end
            if (got.length_ms !== want.length_ms) begin
                $error("length_ms: expected %0d, got %0d", want.length_ms, got.length_ms);
                mismatches++;
            end
            if (got.occurred_ms !== want.occurred_ms) begin
                $error("occurred_ms: expected %0d, got %0d", want.occurred_ms, got.occurred_ms);
                mismatches++;
            end
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_t              s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_t             m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    press_event_scoreboard pred = new();

    int                send_idle_pct  = 0;
    int                sink_stall_pct = 0;
    bit                holdoff_req    = 1'b0;
    int                holdoff_left   = 0;
    int                quiet_cycles   = 0;
    logic [TIME_W-1:0] clock_ms       = '0;
    logic [NUM_KEYS-1:0] key_levels   = '0;

    button_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Event sink: check each transfer, then pick ready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pred.check_event(m_data);
        if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = LONG_STALL;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample, idling first at random; leaves s_valid high after the transfer.
    task automatic send_sample(input logic [NUM_KEYS-1:0] lv, input logic [TIME_W-1:0] t);
        in_t smp;
        smp.pressed_levels = lv;
        smp.now_ms         = t;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        pred.note_sample(smp);
    endtask

    task automatic wait_drained();
        while (pred.expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timing_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred.write_reg(idx, val);
    endtask

    task automatic load_timing(input int db, input int hd, input int lg, input int rp,
                               input int dw);
        write_timing_reg(REG_DEBOUNCE, CFG_W'(db));
        write_timing_reg(REG_HOLD,     CFG_W'(hd));
        write_timing_reg(REG_LONG,     CFG_W'(lg));
        write_timing_reg(REG_REPEAT,   CFG_W'(rp));
        write_timing_reg(REG_DOUBLE,   CFG_W'(dw));
    endtask

    // Hand-picked sequence under the power-up timing (40/200/650/260/300).
    task automatic run_directed();
        send_sample(3'b000, 32'd0);
        send_sample(3'b001, 32'd100);          // key 0 goes down
        send_sample(3'b001, 32'd140);          // debounced, press edge armed
        send_sample(3'b001, 32'd141);          // press
        send_sample(3'b000, 32'd160);
        send_sample(3'b000, 32'd200);          // short, 60 ms
        send_sample(3'b000, 32'd201);          // release
        send_sample(3'b001, 32'd250);
        send_sample(3'b001, 32'd290);
        send_sample(3'b001, 32'd291);
        send_sample(3'b000, 32'd320);
        send_sample(3'b000, 32'd360);          // second release inside window: double
        send_sample(3'b000, 32'd361);
        send_sample(3'b001, 32'd400);
        send_sample(3'b001, 32'd440);
        send_sample(3'b001, 32'd441);
        send_sample(3'b001, 32'd650);          // hold
        send_sample(3'b001, 32'd1100);         // first long
        send_sample(3'b001, 32'd1400);         // long repeat
        send_sample(3'b000, 32'd1500);
        send_sample(3'b000, 32'd1540);         // long release
        send_sample(3'b000, 32'd1541);
        send_sample(3'b111, 32'd2000);         // all keys down together
        send_sample(3'b111, 32'd2040);         // three press edges armed at once
        send_sample(3'b111, 32'hFFFF_FFFF);    // time jumps to the top of the range
        s_valid <= 1'b0;
    endtask

    // Mostly plausible key activity: time advances, keys flip now and then,
    // with occasional contact bounce and random samples mixed in.
    task automatic run_random(input int n_items, input int toggle_pct, input int max_step);
        logic [NUM_KEYS-1:0] lv;
        int                  roll;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                clock_ms = $urandom();
                lv       = NUM_KEYS'($urandom());
            end else begin
                if (roll < 14)
                    clock_ms += $urandom_range(5);
                else if (roll < 20)
                    clock_ms += $urandom_range(8 * max_step);
                else
                    clock_ms += $urandom_range(max_step);
                for (int k = 0; k < NUM_KEYS; k++)
                    if ($urandom_range(99) < toggle_pct)
                        key_levels[k] = !key_levels[k];
                lv = key_levels;
                // one-sample bounce on some keys
                if (roll >= 94)
                    lv ^= NUM_KEYS'($urandom_range(1, (1 << NUM_KEYS) - 1));
            end
            send_sample(lv, clock_ms);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-up timing, no idling
        run_directed();
        run_random(250, 6, 40);

        // every threshold at zero, slow sender
        load_timing(0, 0, 0, 0, 0);
        send_idle_pct = 73;
        run_random(250, 20, 5);

        // every threshold at full scale, slow receiver; unused indexes must be dropped
        load_timing(65535, 65535, 65535, 65535, 65535);
        for (int i = REG_DOUBLE + 1; i < (1 << IDX_W); i++)
            write_timing_reg(IDX_W'(i), CFG_W'($urandom()));
        send_idle_pct  = 0;
        sink_stall_pct = 73;
        run_random(250, 5, 20000);

        // random thresholds, both sides idling
        load_timing($urandom_range(30), $urandom_range(300), $urandom_range(700),
                    $urandom_range(300), $urandom_range(400));
        send_idle_pct  = 28;
        sink_stall_pct = 28;
        run_random(250, 6, 40);

        // long receiver hold-off while events come on nearly every sample
        load_timing(0, 5, 10, 3, 50);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        holdoff_req    = 1'b1;
        run_random(150, 30, 8);

        // timestamps crossing the 32-bit wrap
        load_timing($urandom_range(60), $urandom_range(300), $urandom_range(700),
                    $urandom_range(300), $urandom_range(400));
        wait_drained();
        clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        run_random(150, 8, 40);

        wait_drained();
        if (pred.mismatches == 0 && pred.expected_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bpc_pkg.sv
src/bpc_lane.sv
src/bpc_merge.sv
src/bpc_out_buf.sv
src/button_press_classifier.sv
dv/button_press_classifier_tb.sv
